/* rtl/pcienum_pkg.sv */
// ----------------------------------------------------------------------------
// PCI enumerator package
// Shared types and constants for the configuration space scan engine.
// ----------------------------------------------------------------------------
package pcienum_pkg;

  // Device table size and the width of the found counter.
  localparam int MAX_FOUND = 32;
  localparam int COUNT_W   = $clog2(MAX_FOUND + 1);
  localparam int INDEX_W   = 5;

  // Depth of the command queue between the front and the back.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Number of BAR records in one device.
  localparam int NUM_BARS = 6;

  // Input modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_HDR  = 2'd1;
  localparam logic [1:0] KIND_BAR  = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  // Configuration dword offsets.
  localparam logic [7:0] OFF_ID    = 8'h00;
  localparam logic [7:0] OFF_CLASS = 8'h08;
  localparam logic [7:0] OFF_HDR   = 8'h0C;
  localparam logic [7:0] OFF_IRQ   = 8'h3C;
  localparam logic [7:0] OFF_BAR0  = 8'h10;

  // Scan limits and the empty-function vendor code.
  localparam logic [7:0]  BUS_LAST    = 8'd255;
  localparam logic [4:0]  SLOT_LAST   = 5'd31;
  localparam logic [2:0]  FUNC_LAST   = 3'd7;
  localparam logic [2:0]  BAR_LAST    = 3'd5;
  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;

  // One input item.
  typedef struct packed {
    logic        mode;
    logic [31:0] read_data;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [7:0]  bus_number;
    logic [4:0]  slot_number;
    logic [2:0]  function_number;
    logic [7:0]  reg_offset;
    logic [4:0]  device_index;
    logic [31:0] id_word;
    logic [23:0] class_triple;
    logic [6:0]  header_kind;
    logic [7:0]  interrupt_line;
    logic [31:0] bar_value;
  } res_t;

  // Command from the front to the back. A command is an optional record
  // (a header record, possibly followed by six zero BAR records, or one BAR
  // record) and always a closing read request or done result.
  typedef struct packed {
    logic        has_hdr;
    logic        has_bar;
    logic        zero_bars;
    logic        tail_done;
    logic [7:0]  rec_bus;
    logic [4:0]  rec_slot;
    logic [2:0]  rec_func;
    logic [4:0]  index;
    logic [31:0] id;
    logic [23:0] cls;
    logic [6:0]  hdr;
    logic [7:0]  irq;
    logic [7:0]  bar_off;
    logic [31:0] bar;
    logic [7:0]  tail_bus;
    logic [4:0]  tail_slot;
    logic [2:0]  tail_func;
    logic [7:0]  tail_off;
  } cmd_t;

endpackage

/* rtl/pcienum_front.sv */
// ----------------------------------------------------------------------------
// PCI enumerator front end
// Accepts start and read completion items, steps the scan cursor and the
// per-function read sequence, and issues one command per item that causes
// results.
// ----------------------------------------------------------------------------
module pcienum_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  pcienum_pkg::item_t  item,
  output logic                q_push,
  output pcienum_pkg::cmd_t   q_cmd,
  input  logic                q_full
);
  import pcienum_pkg::*;

  // Read sequence phases.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_VENDOR = 3'd1;
  localparam logic [2:0] PH_CLASS  = 3'd2;
  localparam logic [2:0] PH_HEADER = 3'd3;
  localparam logic [2:0] PH_IRQ    = 3'd4;
  localparam logic [2:0] PH_BAR    = 3'd5;

  logic [7:0]         bus, bus_next;
  logic [4:0]         slot, slot_next;
  logic [2:0]         func, func_next;
  logic [2:0]         phase, phase_next;
  logic               mf, mf_next;
  logic [COUNT_W-1:0] found, found_next;
  logic [31:0]        held_id, held_id_next;
  logic [23:0]        held_class, held_class_next;
  logic [6:0]         held_hdr, held_hdr_next;
  logic [2:0]         bar_cnt, bar_cnt_next;

  logic               accept;
  logic [COUNT_W-1:0] found_after;
  logic               adv_full;
  logic               adv_end;
  logic               adv_func;
  logic               use_adv;
  logic [2:0]         bar_cnt_inc;

  assign full   = q_full;
  assign accept = push && !full;
  assign bar_cnt_inc = 3'(bar_cnt + 3'd1);

  // Advance decision: the count seen is the one after this item's update.
  assign found_after = (phase == PH_IRQ) ? COUNT_W'(found + COUNT_W'(1)) : found;
  assign adv_full    = found_after >= COUNT_W'(MAX_FOUND);
  assign adv_func    = mf && (func != FUNC_LAST);
  assign adv_end     = !adv_func && (slot == SLOT_LAST) && (bus == BUS_LAST);

  // Next state and command for the accepted item.
  always_comb begin
    bus_next        = bus;
    slot_next       = slot;
    func_next       = func;
    phase_next      = phase;
    mf_next         = mf;
    found_next      = found;
    held_id_next    = held_id;
    held_class_next = held_class;
    held_hdr_next   = held_hdr;
    bar_cnt_next    = bar_cnt;
    use_adv         = 1'b0;
    q_push          = 1'b0;
    q_cmd           = '0;
    q_cmd.rec_bus   = bus;
    q_cmd.rec_slot  = slot;
    q_cmd.rec_func  = func;
    q_cmd.tail_bus  = bus;
    q_cmd.tail_slot = slot;
    q_cmd.tail_func = func;

    if (accept) begin
      if (item.mode == MODE_START) begin
        bus_next        = '0;
        slot_next       = '0;
        func_next       = '0;
        mf_next         = 1'b0;
        found_next      = '0;
        held_id_next    = '0;
        held_class_next = '0;
        held_hdr_next   = '0;
        bar_cnt_next    = '0;
        phase_next      = PH_VENDOR;
        q_push          = 1'b1;
        q_cmd.tail_bus  = '0;
        q_cmd.tail_slot = '0;
        q_cmd.tail_func = '0;
        q_cmd.tail_off  = OFF_ID;
      end else begin
        case (phase)
          PH_VENDOR: begin
            q_push = 1'b1;
            if (item.read_data[15:0] == VENDOR_NONE) begin
              use_adv = 1'b1;
            end else begin
              held_id_next   = item.read_data;
              phase_next     = PH_CLASS;
              q_cmd.tail_off = OFF_CLASS;
            end
          end
          PH_CLASS: begin
            q_push          = 1'b1;
            held_class_next = item.read_data[31:8];
            phase_next      = PH_HEADER;
            q_cmd.tail_off  = OFF_HDR;
          end
          PH_HEADER: begin
            q_push = 1'b1;
            if (func == 3'd0) begin
              mf_next = item.read_data[23];
            end
            held_hdr_next  = item.read_data[22:16];
            phase_next     = PH_IRQ;
            q_cmd.tail_off = OFF_IRQ;
          end
          PH_IRQ: begin
            q_push        = 1'b1;
            q_cmd.has_hdr = 1'b1;
            q_cmd.index   = INDEX_W'(found);
            q_cmd.id      = held_id;
            q_cmd.cls     = held_class;
            q_cmd.hdr     = held_hdr;
            q_cmd.irq     = item.read_data[7:0];
            found_next    = found_after;
            if (held_hdr == 7'd0) begin
              bar_cnt_next   = '0;
              phase_next     = PH_BAR;
              q_cmd.tail_off = OFF_BAR0;
            end else begin
              q_cmd.zero_bars = 1'b1;
              use_adv         = 1'b1;
            end
          end
          PH_BAR: begin
            q_push        = 1'b1;
            q_cmd.has_bar = 1'b1;
            q_cmd.index   = INDEX_W'(found - COUNT_W'(1));
            q_cmd.bar     = item.read_data;
            q_cmd.bar_off = OFF_BAR0 + {3'b000, bar_cnt, 2'b00};
            if (bar_cnt < BAR_LAST) begin
              bar_cnt_next   = bar_cnt_inc;
              q_cmd.tail_off = OFF_BAR0 + {3'b000, bar_cnt_inc, 2'b00};
            end else begin
              use_adv = 1'b1;
            end
          end
          default: begin
            // Idle: a completion with nothing pending is dropped.
            q_push = 1'b0;
          end
        endcase
      end

      // Step to the next function, slot or bus, or close the scan.
      if (use_adv) begin
        if (adv_full || adv_end) begin
          phase_next      = PH_IDLE;
          q_cmd.tail_done = 1'b1;
          q_cmd.tail_bus  = '0;
          q_cmd.tail_slot = '0;
          q_cmd.tail_func = '0;
        end else begin
          phase_next = PH_VENDOR;
          if (adv_func) begin
            func_next = 3'(func + 3'd1);
          end else begin
            func_next = '0;
            mf_next   = 1'b0;
            if (slot != SLOT_LAST) begin
              slot_next = 5'(slot + 5'd1);
            end else begin
              slot_next = '0;
              bus_next  = 8'(bus + 8'd1);
            end
          end
          q_cmd.tail_bus  = bus_next;
          q_cmd.tail_slot = slot_next;
          q_cmd.tail_func = func_next;
          q_cmd.tail_off  = OFF_ID;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus     <= '0;
      slot    <= '0;
      func    <= '0;
      phase   <= PH_IDLE;
      mf      <= 1'b0;
      found   <= '0;
      bar_cnt <= '0;
    end else begin
      bus     <= bus_next;
      slot    <= slot_next;
      func    <= func_next;
      phase   <= phase_next;
      mf      <= mf_next;
      found   <= found_next;
      bar_cnt <= bar_cnt_next;
    end
  end

  // Held header fields of the current function.
  always_ff @(posedge clk) begin
    held_id    <= held_id_next;
    held_class <= held_class_next;
    held_hdr   <= held_hdr_next;
  end

  // The device count never passes the table size.
  a_found_bound: assert property (@(posedge clk) disable iff (rst)
    found <= COUNT_W'(MAX_FOUND))
    else $error("found count beyond table size");

  // A done command leaves the sequence idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_cmd.tail_done) |=> (phase == PH_IDLE))
    else $error("scan did not go idle after done");

  // BAR reads happen only for type-0 headers.
  a_bar_type0: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BAR) |-> (held_hdr == 7'd0))
    else $error("BAR phase with non type-0 header");

endmodule

/* rtl/pcienum_cmdq.sv */
// ----------------------------------------------------------------------------
// PCI enumerator command queue
// Short first-in first-out buffer of commands between the front and back.
// ----------------------------------------------------------------------------
module pcienum_cmdq (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  pcienum_pkg::cmd_t  wr_cmd,
  output logic               q_full,
  output logic               rd_valid,
  output pcienum_pkg::cmd_t  rd_cmd,
  input  logic               rd
);
  import pcienum_pkg::*;

  cmd_t                  mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign q_full   = count == CMDQ_CNT_W'(CMDQ_DEPTH);
  assign rd_valid = count != '0;
  assign rd_cmd   = mem[rd_ptr];
  assign do_wr    = wr && !q_full;
  assign do_rd    = rd && rd_valid;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= CMDQ_PTR_W'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= CMDQ_PTR_W'(rd_ptr + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count <= CMDQ_CNT_W'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= CMDQ_CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

/* rtl/pcienum_back.sv */
// ----------------------------------------------------------------------------
// PCI enumerator back end
// Expands each command into its result items, which enter the result
// register one per cycle while it is empty or being popped.
// ----------------------------------------------------------------------------
module pcienum_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  pcienum_pkg::cmd_t  q_cmd,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output pcienum_pkg::res_t  result
);
  import pcienum_pkg::*;

  logic [2:0] seq;
  logic [2:0] last_pos;
  logic [2:0] bar_idx;
  logic       out_valid;
  logic       load;
  res_t       res;

  assign last_pos = q_cmd.zero_bars ? 3'(NUM_BARS + 1) : {2'b00, q_cmd.has_hdr | q_cmd.has_bar};
  assign bar_idx  = 3'(seq - 3'd1);
  assign load     = q_valid && (!out_valid || pop);
  assign q_pop    = load && (seq == last_pos);
  assign empty    = !out_valid;

  // Result at the current position of the head command.
  always_comb begin
    res = '0;
    if (seq == last_pos) begin
      res.last = 1'b1;
      if (q_cmd.tail_done) begin
        res.kind = KIND_DONE;
      end else begin
        res.kind            = KIND_REQ;
        res.bus_number      = q_cmd.tail_bus;
        res.slot_number     = q_cmd.tail_slot;
        res.function_number = q_cmd.tail_func;
        res.reg_offset      = q_cmd.tail_off;
      end
    end else begin
      res.bus_number      = q_cmd.rec_bus;
      res.slot_number     = q_cmd.rec_slot;
      res.function_number = q_cmd.rec_func;
      res.device_index    = q_cmd.index;
      if (seq == 3'd0 && q_cmd.has_hdr) begin
        res.kind           = KIND_HDR;
        res.id_word        = q_cmd.id;
        res.class_triple   = q_cmd.cls;
        res.header_kind    = q_cmd.hdr;
        res.interrupt_line = q_cmd.irq;
      end else if (seq == 3'd0) begin
        res.kind       = KIND_BAR;
        res.reg_offset = q_cmd.bar_off;
        res.bar_value  = q_cmd.bar;
      end else begin
        res.kind       = KIND_BAR;
        res.reg_offset = OFF_BAR0 + {3'b000, bar_idx, 2'b00};
      end
    end
  end

  // Position within the head command.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
    end else if (load) begin
      seq <= (seq == last_pos) ? 3'd0 : 3'(seq + 3'd1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

  // Mid-command positions only exist while the command is still at the head.
  a_seq_head: assert property (@(posedge clk) disable iff (rst)
    (seq != 3'd0) |-> q_valid)
    else $error("burst position without a command");

  // The position never runs past the final result of the head command.
  a_seq_bound: assert property (@(posedge clk) disable iff (rst)
    (seq != 3'd0) |-> (seq <= last_pos))
    else $error("burst position past the final result");

  // The final result of a command rewinds the position.
  a_seq_rewind: assert property (@(posedge clk) disable iff (rst)
    (load && res.last) |=> (seq == 3'd0))
    else $error("position not rewound after final result");

endmodule

/* rtl/pci_config_space_enumerator.sv */
// ----------------------------------------------------------------------------
// PCI configuration space enumerator
// Brute-force scan of buses, slots and functions driven by configuration
// read completions; emits read requests, device and BAR records, and done.
//
//   Channel   Handshake          Payload
//   input     push / full        item   (mode, read_data)
//   result    empty / pop        result (kind, last, location, records)
//
// The front takes one item per cycle while the command queue (4 deep) has
// room. The back emits one result per cycle unless its output waits for pop,
// so an item gives 1 to 8 results: a header, six zero BARs and a request is 8.
// Reset is synchronous: the scan goes idle and both queues empty.
// full rises when the command queue is full; a result stays until popped.
// ----------------------------------------------------------------------------
module pci_config_space_enumerator (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  pcienum_pkg::item_t item,
  output logic               empty,
  input  logic               pop,
  output pcienum_pkg::res_t  result
);
  import pcienum_pkg::*;

  logic q_push;
  cmd_t q_cmd_in;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd_out;
  logic q_pop;

  // Front: cursor and read sequence.
  pcienum_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_cmd  (q_cmd_in),
    .q_full (q_full)
  );

  // Command queue.
  pcienum_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_cmd   (q_cmd_in),
    .q_full   (q_full),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd_out),
    .rd       (q_pop)
  );

  // Back: result expansion.
  pcienum_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd_out),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
